// ===== sv/pattern_permutation_rank_defines.svh =====
// assertion macros shared by the checker of the pattern permutation ranker
// depends on nothing; the asserting file supplies clk and arst_n
`ifndef PATTERN_PERMUTATION_RANK_DEFINES_SVH
`define PATTERN_PERMUTATION_RANK_DEFINES_SVH

// same-cycle implication, off during reset
`define PPR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pattern_permutation_rank: assertion failed");

// next-cycle implication, off during reset
`define PPR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pattern_permutation_rank: assertion failed");

`endif

// ===== sv/ppr_pkg.sv =====
// shared constants, types and the rank weight table of the pattern ranker
// depends on nothing
package ppr_pkg;

	localparam int BOARD_CELLS = 16;
	localparam int MAX_PATTERN = 8;
	localparam int KMAX        = (MAX_PATTERN < BOARD_CELLS) ? MAX_PATTERN : BOARD_CELLS;
	localparam int TILE_W      = 4;
	localparam int BOARD_W     = 64;
	localparam int POS_W       = $clog2(BOARD_CELLS);
	localparam int KLEN_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int SIZE_W      = 4;
	localparam int TILES_W     = 32;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = 1;
	localparam int RANK_W      = 29;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(8);
	localparam logic [TILES_W-1:0] TILES_RESET = 32'h7654_3210;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_SIZE  = 1'b0,
		REG_PATTERN_TILES = 1'b1
	} cfg_reg_t;

	// classified word passed from front to back
	typedef struct packed {
		logic [MAX_PATTERN-1:0][POS_W-1:0] pos;
		logic [KLEN_W-1:0]                 klen;
		logic                              bad;
	} ppr_word_t;

	typedef logic [MAX_PATTERN-1:0][MAX_PATTERN-1:0][RANK_W-1:0] weight_tab_t;

	// weight of digit j for pattern length k: (N-1-j)! / (N-k)!
	function automatic weight_tab_t build_weights();
		weight_tab_t t;
		longint      w;
		int          kk;
		int          jj;
		int          m;
		t = '0;
		for (kk = 1; kk <= MAX_PATTERN; kk++) begin
			for (jj = 0; jj < kk; jj++) begin
				w = 1;
				for (m = BOARD_CELLS - kk + 1; m + jj + 1 <= BOARD_CELLS; m++) begin
					w = w * m;
				end
				t[kk-1][jj] = w[RANK_W-1:0];
			end
		end
		return t;
	endfunction

	localparam weight_tab_t WEIGHTS = build_weights();

	// largest rank: N!/(N-k)! - 1 at the longest pattern
	localparam longint RANK_MAX = longint'(BOARD_CELLS) * longint'(WEIGHTS[KMAX-1][0]) - 1;

endpackage

// ===== sv/ppr_front.sv =====
// front: takes a board word, finds each pattern tile's cell and flags bad boards
// depends on ppr_pkg
module ppr_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                board_valid,
	input  logic [ppr_pkg::BOARD_W-1:0]         board,
	output logic                                board_stall,
	input  logic [ppr_pkg::KLEN_W-1:0]          klen_m1,
	input  logic [ppr_pkg::TILES_W-1:0]         tiles,
	output logic                                push_valid,
	output ppr_pkg::ppr_word_t                  push_word,
	input  logic                                queue_full
);

	logic [ppr_pkg::MAX_PATTERN-1:0][ppr_pkg::BOARD_CELLS-1:0] hit;
	logic [ppr_pkg::MAX_PATTERN-1:0][ppr_pkg::TILE_W-1:0]      tile;
	logic [ppr_pkg::MAX_PATTERN-1:0]                           used;
	ppr_pkg::ppr_word_t                                        word_d;
	ppr_pkg::ppr_word_t                                        word_s1;
	logic                                                      valid_s1;
	logic                                                      load;

	// tile match vectors per pattern index
	always_comb begin
		for (int j = 0; j < ppr_pkg::MAX_PATTERN; j++) begin
			tile[j] = tiles[j*ppr_pkg::TILE_W +: ppr_pkg::TILE_W];
			used[j] = (ppr_pkg::KLEN_W'(j) <= klen_m1);
			for (int c = 0; c < ppr_pkg::BOARD_CELLS; c++) begin
				hit[j][c] = (board[c*ppr_pkg::TILE_W +: ppr_pkg::TILE_W] == tile[j]);
			end
		end
	end

	// encode positions, check single hit and repeated pattern tiles
	always_comb begin
		word_d      = '0;
		word_d.klen = klen_m1;
		for (int j = 0; j < ppr_pkg::MAX_PATTERN; j++) begin
			for (int c = 0; c < ppr_pkg::BOARD_CELLS; c++) begin
				if (hit[j][c]) begin
					word_d.pos[j] = word_d.pos[j] | ppr_pkg::POS_W'(c);
				end
			end
			if (used[j] && ((hit[j] == '0) ||
					((hit[j] & (hit[j] - ppr_pkg::BOARD_CELLS'(1))) != '0))) begin
				word_d.bad = 1'b1;
			end
			for (int i = 0; i < j; i++) begin
				if (used[j] && (tile[i] == tile[j])) begin
					word_d.bad = 1'b1;
				end
			end
		end
	end

	// front register, frees when the queue takes its word
	assign load        = !valid_s1 || !queue_full;
	assign board_stall = !load;
	assign push_valid  = valid_s1;
	assign push_word   = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= board_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && board_valid) begin
			word_s1 <= word_d;
		end
	end

endmodule

// ===== sv/ppr_queue.sv =====
// short queue of classified words between front and back
// depends on ppr_pkg
module ppr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  ppr_pkg::ppr_word_t  push_word,
	output logic                full,
	output logic                head_valid,
	output ppr_pkg::ppr_word_t  head_word,
	input  logic                pop_ready
);

	ppr_pkg::ppr_word_t          mem_q [ppr_pkg::QUEUE_DEPTH];
	logic [ppr_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [ppr_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [ppr_pkg::QCNT_W-1:0]  count_q;
	logic                        push;
	logic                        pop;

	assign full       = (count_q == ppr_pkg::QCNT_W'(ppr_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_word  = mem_q[rd_ptr_q];
	assign push       = push_valid && !full;
	assign pop        = head_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == ppr_pkg::QPTR_W'(ppr_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == ppr_pkg::QPTR_W'(ppr_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

// ===== sv/ppr_back.sv =====
// back: digits, weighted products and their sum, with the output register
// depends on ppr_pkg
module ppr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  ppr_pkg::ppr_word_t          head_word,
	output logic                        pop_ready,
	output logic                        rank_valid,
	input  logic                        rank_stall,
	output logic [ppr_pkg::RANK_W-1:0]  rank,
	output logic                        bad_board
);

	localparam int NP = ppr_pkg::MAX_PATTERN;

	logic [NP-1:0][ppr_pkg::POS_W-1:0]          cnt;
	logic [NP-1:0][ppr_pkg::POS_W-1:0]          digit;
	logic [NP-1:0][ppr_pkg::RANK_W-1:0]         prod;
	logic [NP-1:0][ppr_pkg::RANK_W-1:0]         prod_s2;
	logic [(NP+1)/2-1:0][ppr_pkg::RANK_W-1:0]   pair_d;
	logic [(NP+1)/2-1:0][ppr_pkg::RANK_W-1:0]   pair_s3;
	logic [ppr_pkg::RANK_W-1:0]          total;
	logic                                bad_s2;
	logic                                bad_s3;
	logic                                valid_s2;
	logic                                valid_s3;
	logic [ppr_pkg::RANK_W-1:0]          rank_s4;
	logic                                bad_s4;
	logic                                valid_s4;
	logic                                en_s2;
	logic                                en_s3;
	logic                                en_s4;

	// stage enables, a stage moves when the one after it is free
	assign en_s4     = !valid_s4 || !rank_stall;
	assign en_s3     = !valid_s3 || en_s4;
	assign en_s2     = !valid_s2 || en_s3;
	assign pop_ready = en_s2;

	// digits: position less the earlier positions below it, times the weight
	always_comb begin
		for (int j = 0; j < NP; j++) begin
			cnt[j] = '0;
			for (int i = 0; i < j; i++) begin
				if (head_word.pos[i] < head_word.pos[j]) begin
					cnt[j] = cnt[j] + 1'b1;
				end
			end
			digit[j] = head_word.pos[j] - cnt[j];
			if (ppr_pkg::KLEN_W'(j) <= head_word.klen) begin
				prod[j] = ppr_pkg::RANK_W'(
					{{(ppr_pkg::RANK_W-ppr_pkg::POS_W){1'b0}}, digit[j]} *
					ppr_pkg::WEIGHTS[head_word.klen][j]);
			end else begin
				prod[j] = '0;
			end
		end
	end

	// pairwise sums of products
	always_comb begin
		pair_d = '0;
		for (int p = 0; p < NP; p += 2) begin
			if (p + 1 < NP) begin
				pair_d[p/2] = prod_s2[p] + prod_s2[p+1];
			end else begin
				pair_d[p/2] = prod_s2[p];
			end
		end
	end

	// final sum of the pair sums
	always_comb begin
		total = '0;
		for (int p = 0; p < (NP + 1) / 2; p++) begin
			total = total + pair_s3[p];
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s2) valid_s2 <= head_valid;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (en_s2 && head_valid) begin
			prod_s2 <= prod;
			bad_s2  <= head_word.bad;
		end
		if (en_s3 && valid_s2) begin
			pair_s3 <= pair_d;
			bad_s3  <= bad_s2;
		end
		if (en_s4 && valid_s3) begin
			rank_s4 <= bad_s3 ? '0 : total;
			bad_s4  <= bad_s3;
		end
	end

	assign rank_valid = valid_s4;
	assign rank       = rank_s4;
	assign bad_board  = bad_s4;

endmodule

// ===== sv/pattern_permutation_rank.sv =====
// path: an accepted board word passes the front register, the queue and the back
// stages before rank_valid rises, and waits longer only while the output is stalled
// throughput: one board word per cycle while the output is not stalled, set by the front
// register, the 2-entry queue and the three back stages (products, pair sums, final sum)
// reset: asynchronous, clears all valids and the queue; pattern_size = 8, tiles 0..7
module pattern_permutation_rank (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [ppr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ppr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            board_valid,
	output logic                            board_stall,
	input  logic [ppr_pkg::BOARD_W-1:0]     board,
	output logic                            rank_valid,
	input  logic                            rank_stall,
	output logic [ppr_pkg::RANK_W-1:0]      rank,
	output logic                            bad_board
);

	logic [ppr_pkg::SIZE_W-1:0]   size_q;
	logic [ppr_pkg::TILES_W-1:0]  tiles_q;
	logic [ppr_pkg::KLEN_W-1:0]   klen_m1;
	logic                         push_valid;
	ppr_pkg::ppr_word_t           push_word;
	logic                         queue_full;
	logic                         head_valid;
	ppr_pkg::ppr_word_t           head_word;
	logic                         pop_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= ppr_pkg::SIZE_RESET;
			tiles_q <= ppr_pkg::TILES_RESET;
		end else if (cfg_write) begin
			unique case (ppr_pkg::cfg_reg_t'(cfg_index))
				ppr_pkg::REG_PATTERN_SIZE:  size_q  <= cfg_data[ppr_pkg::SIZE_W-1:0];
				ppr_pkg::REG_PATTERN_TILES: tiles_q <= cfg_data[ppr_pkg::TILES_W-1:0];
				default: ;
			endcase
		end
	end

	// pattern length clamped to 1..KMAX, kept as length minus one
	always_comb begin
		if (size_q == '0) begin
			klen_m1 = '0;
		end else if (size_q > ppr_pkg::SIZE_W'(ppr_pkg::KMAX)) begin
			klen_m1 = ppr_pkg::KLEN_W'(ppr_pkg::KMAX - 1);
		end else begin
			klen_m1 = ppr_pkg::KLEN_W'(size_q - 1'b1);
		end
	end

	ppr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.board_valid (board_valid),
		.board       (board),
		.board_stall (board_stall),
		.klen_m1     (klen_m1),
		.tiles       (tiles_q),
		.push_valid  (push_valid),
		.push_word   (push_word),
		.queue_full  (queue_full)
	);

	ppr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_word  (push_word),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_word  (head_word),
		.pop_ready  (pop_ready)
	);

	ppr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_word  (head_word),
		.pop_ready  (pop_ready),
		.rank_valid (rank_valid),
		.rank_stall (rank_stall),
		.rank       (rank),
		.bad_board  (bad_board)
	);

endmodule

// ===== sv/ppr_check.sv =====
// port-level checker for the pattern ranker, bound to the top level
// depends on ppr_pkg and pattern_permutation_rank_defines.svh
`include "pattern_permutation_rank_defines.svh"

module ppr_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            board_valid,
	input  logic                            board_stall,
	input  logic [ppr_pkg::BOARD_W-1:0]     board,
	input  logic                            rank_valid,
	input  logic                            rank_stall,
	input  logic [ppr_pkg::RANK_W-1:0]      rank,
	input  logic                            bad_board
);

	// a bad board always reports rank zero
	`PPR_ASSERT_IMP(a_bad_zero, rank_valid && bad_board, rank == '0)

	// rank never exceeds the database size
	`PPR_ASSERT_IMP(a_rank_range, rank_valid, longint'(rank) <= ppr_pkg::RANK_MAX)

	// input backpressure only arises when the pipe is full down to the output
	`PPR_ASSERT_IMP(a_stall_full, board_stall, rank_valid)

	// a stalled word holds
	`PPR_ASSERT_NXT(a_out_hold, rank_valid && rank_stall,
		rank_valid && $stable(rank) && $stable(bad_board))

	// an offered board word holds while stalled
	`PPR_ASSERT_NXT(a_in_hold, board_valid && board_stall, board_valid && $stable(board))

endmodule

bind pattern_permutation_rank ppr_check u_check (.*);

// ===== test/rank_checker.sv =====
// checker for the pattern permutation ranker: watches the config port and both channels,
// predicts each rank word from its own copy of the registers and compares in order
// depends on ppr_pkg for widths, reset values and register indexes
module rank_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [ppr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           board_valid,
	input  logic                           board_stall,
	input  logic [ppr_pkg::BOARD_W-1:0]    board,
	input  logic                           rank_valid,
	input  logic                           rank_stall,
	input  logic [ppr_pkg::RANK_W-1:0]     rank,
	input  logic                           bad_board,
	output int                             fail_count,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ppr_pkg::RANK_W-1:0] rank;
		logic                       bad;
	} rank_word_t;

	logic [ppr_pkg::SIZE_W-1:0]  size_reg;
	logic [ppr_pkg::TILES_W-1:0] tiles_reg;
	rank_word_t                  expected_ranks[$];

	// rank of the pattern tile cells taken as a partial permutation of the board
	function automatic rank_word_t rank_of_board(input logic [ppr_pkg::BOARD_W-1:0] b,
			input logic [ppr_pkg::SIZE_W-1:0] sz, input logic [ppr_pkg::TILES_W-1:0] tl);
		rank_word_t r;
		int         k, j, i, c, m, hits;
		int         cell_of[ppr_pkg::MAX_PATTERN];
		logic [3:0] tile;
		logic       bad;
		longint     digit, weight, sum;
		// zero counts as one tile, too many saturates
		k = int'(sz);
		if (k < 1) k = 1;
		if (k > ppr_pkg::MAX_PATTERN) k = ppr_pkg::MAX_PATTERN;
		if (k > ppr_pkg::BOARD_CELLS) k = ppr_pkg::BOARD_CELLS;
		bad = 1'b0;
		// locate each pattern tile, flag list repeats and tiles not found once on the board
		for (j = 0; j < k; j++) begin
			tile = tl[4*j +: 4];
			hits = 0;
			cell_of[j] = 0;
			for (i = 0; i < j; i++) begin
				if (tl[4*i +: 4] == tile) bad = 1'b1;
			end
			for (c = 0; c < ppr_pkg::BOARD_CELLS; c++) begin
				if (b[4*c +: 4] == tile) begin
					cell_of[j] = c;
					hits++;
				end
			end
			if (hits != 1) bad = 1'b1;
		end
		// digits lowered by earlier cells below, weighted by falling factorials
		sum = 0;
		if (!bad) begin
			for (j = 0; j < k; j++) begin
				digit = cell_of[j];
				for (i = 0; i < j; i++) begin
					if (cell_of[i] < cell_of[j]) digit--;
				end
				weight = 1;
				for (m = ppr_pkg::BOARD_CELLS - k + 1; m <= ppr_pkg::BOARD_CELLS - 1 - j;
						m++) begin
					weight = weight * m;
				end
				sum = sum + digit * weight;
			end
		end
		r.rank = bad ? '0 : sum[ppr_pkg::RANK_W-1:0];
		r.bad  = bad;
		return r;
	endfunction

	// predict on board words, compare on rank words
	always @(posedge clk or negedge arst_n) begin
		rank_word_t want;
		if (!arst_n) begin
			size_reg   = ppr_pkg::SIZE_RESET;
			tiles_reg  = ppr_pkg::TILES_RESET;
			fail_count = 0;
			expected_ranks.delete();
		end else begin
			if (board_valid && !board_stall)
				expected_ranks = {expected_ranks, rank_of_board(board, size_reg, tiles_reg)};
			if (cfg_write) begin
				case (ppr_pkg::cfg_reg_t'(cfg_index))
					ppr_pkg::REG_PATTERN_SIZE:  size_reg = cfg_data[ppr_pkg::SIZE_W-1:0];
					ppr_pkg::REG_PATTERN_TILES: tiles_reg = cfg_data[ppr_pkg::TILES_W-1:0];
					default: ;
				endcase
			end
			if (rank_valid && !rank_stall) begin
				if (expected_ranks.size() == 0) begin
					$display("%0t: unexpected rank word: rank %0d bad_board %0b",
						$time, rank, bad_board);
					fail_count++;
				end else begin
					want = expected_ranks.pop_front();
					if (rank !== want.rank || bad_board !== want.bad) begin
						$display("%0t: mismatch: expected %0d/%0b, got %0d/%0b",
							$time, want.rank, want.bad, rank, bad_board);
						fail_count++;
					end
				end
			end
		end
		pending = expected_ranks.size();
	end

endmodule

// ===== test/tb.sv =====
// top of the pattern permutation ranker bench: clock, reset, board words, rank stalls
// and register writes; the verdict comes from the failure count of rank_checker
// depends on ppr_pkg, pattern_permutation_rank and rank_checker
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ppr_pkg::BOARD_W-1:0] IDENTITY = 64'hFEDC_BA98_7654_3210;
	localparam logic [ppr_pkg::BOARD_W-1:0] REVERSED = 64'h0123_4567_89AB_CDEF;
	localparam int HOLD_CYCLES  = 80;
	localparam int SETTLE       = 8;
	localparam int PHASES       = 10;
	localparam int PHASE_WORDS  = 43;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_write;
	logic [ppr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ppr_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           board_valid;
	logic                           board_stall;
	logic [ppr_pkg::BOARD_W-1:0]    board;
	logic                           rank_valid;
	logic                           rank_stall;
	logic [ppr_pkg::RANK_W-1:0]     rank;
	logic                           bad_board;
	int                             fail_count;
	int                             pending;
	bit                             gaps_on = 1'b1;
	bit                             hold_off = 1'b0;

	pattern_permutation_rank u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.board_valid (board_valid),
		.board_stall (board_stall),
		.board       (board),
		.rank_valid  (rank_valid),
		.rank_stall  (rank_stall),
		.rank        (rank),
		.bad_board   (bad_board)
	);

	rank_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.board_valid (board_valid),
		.board_stall (board_stall),
		.board       (board),
		.rank_valid  (rank_valid),
		.rank_stall  (rank_stall),
		.rank        (rank),
		.bad_board   (bad_board),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// every tile exactly once, in random cells
	function automatic logic [ppr_pkg::BOARD_W-1:0] shuffled_board();
		logic [3:0]                  cells[ppr_pkg::BOARD_CELLS];
		logic [3:0]                  t;
		logic [ppr_pkg::BOARD_W-1:0] b;
		int                          i, j;
		for (i = 0; i < ppr_pkg::BOARD_CELLS; i++) cells[i] = 4'(i);
		for (i = ppr_pkg::BOARD_CELLS - 1; i > 0; i--) begin
			j = $urandom_range(i, 0);
			t = cells[i];
			cells[i] = cells[j];
			cells[j] = t;
		end
		b = '0;
		for (i = 0; i < ppr_pkg::BOARD_CELLS; i++) b[4*i +: 4] = cells[i];
		return b;
	endfunction

	// mostly legal boards, some with damaged cells, some pure noise
	function automatic logic [ppr_pkg::BOARD_W-1:0] random_board();
		logic [ppr_pkg::BOARD_W-1:0] b;
		int                          r, n, pick;
		r = $urandom_range(9, 0);
		b = shuffled_board();
		if (r == 7 || r == 8) begin
			for (n = 0; n < r - 6; n++) begin
				pick = $urandom_range(ppr_pkg::BOARD_CELLS - 1, 0);
				b[4*pick +: 4] = 4'($urandom_range(15, 0));
			end
		end else if (r == 9) begin
			b = {$urandom, $urandom};
		end
		return b;
	endfunction

	// offer one board word, hold it until taken, then maybe idle
	task automatic put_board(input logic [ppr_pkg::BOARD_W-1:0] b);
		int gap, r;
		board_valid <= 1'b1;
		board <= b;
		@(posedge clk);
		while (board_stall) @(posedge clk);
		gap = 0;
		if (gaps_on) begin
			r = $urandom_range(15, 0);
			if (r >= 14) gap = $urandom_range(25, 5);
			else if (r >= 9) gap = $urandom_range(3, 1);
		end
		if (gap > 0) begin
			board_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait until every rank word is back
	task automatic drain(input int settle);
		board_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic set_reg(input ppr_pkg::cfg_reg_t idx,
			input logic [ppr_pkg::CFG_DATA_W-1:0] v);
		drain(SETTLE);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// rank stalls: short, long, none for a while, or a forced hold-off
	initial begin
		int stall_left, run_left, r;
		bit hold_done;
		stall_left = 0;
		run_left = 0;
		hold_done = 1'b0;
		rank_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off && !hold_done) begin
				stall_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (stall_left == 0 && run_left == 0) begin
				r = $urandom_range(19, 0);
				if (r < 9) stall_left = $urandom_range(3, 1);
				else if (r < 11) stall_left = $urandom_range(30, 8);
				else if (r < 19) run_left = $urandom_range(10, 1);
				else run_left = $urandom_range(120, 40);
			end
			rank_stall <= (stall_left > 0);
			if (stall_left > 0) stall_left--;
			else run_left--;
		end
	end

	// stimulus
	initial begin
		logic [ppr_pkg::CFG_DATA_W-1:0] v;
		logic [ppr_pkg::BOARD_W-1:0]    bw;
		logic [3:0]                     sz;
		int                             ph, n, r;
		arst_n <= 1'b0;
		board_valid <= 1'b0;
		board <= '0;
		cfg_write <= 1'b0;
		cfg_index <= ppr_pkg::REG_PATTERN_SIZE;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pattern: tiles 0..7 over all 16 cells
		put_board(IDENTITY);
		put_board(REVERSED);
		put_board(64'h0);
		put_board(64'hFFFF_FFFF_FFFF_FFFF);
		put_board(64'h3EDC_BA98_7654_3210);
		put_board(64'hFEDC_BA98_7654_3218);
		put_board(64'hFFFF_FFFF_7654_3210);

		// size zero acts as one tile, upper pattern nibbles ignored
		set_reg(ppr_pkg::REG_PATTERN_SIZE, 32'hFFFF_FFF0);
		set_reg(ppr_pkg::REG_PATTERN_TILES, 32'hFFFF_FFF5);
		put_board(IDENTITY);
		put_board(REVERSED);
		put_board(64'h5555_5555_5555_5555);

		// size above the maximum saturates to eight
		set_reg(ppr_pkg::REG_PATTERN_SIZE, 32'h0000_000F);
		set_reg(ppr_pkg::REG_PATTERN_TILES, 32'h89AB_CDEF);
		put_board(IDENTITY);
		put_board(REVERSED);
		put_board(shuffled_board());

		// a tile listed twice within the pattern
		set_reg(ppr_pkg::REG_PATTERN_SIZE, 32'h3);
		set_reg(ppr_pkg::REG_PATTERN_TILES, 32'h0000_0121);
		put_board(IDENTITY);

		// repeats only beyond the pattern length
		set_reg(ppr_pkg::REG_PATTERN_SIZE, 32'h2);
		set_reg(ppr_pkg::REG_PATTERN_TILES, 32'h1111_11FE);
		put_board(IDENTITY);
		put_board(REVERSED);

		// all-ones and all-zeros tile lists
		set_reg(ppr_pkg::REG_PATTERN_SIZE, 32'h8);
		set_reg(ppr_pkg::REG_PATTERN_TILES, 32'hFFFF_FFFF);
		put_board(IDENTITY);
		set_reg(ppr_pkg::REG_PATTERN_SIZE, 32'h1);
		put_board(IDENTITY);
		set_reg(ppr_pkg::REG_PATTERN_TILES, 32'h0);
		put_board(REVERSED);

		// random phases, each with its own pattern
		for (ph = 0; ph < PHASES; ph++) begin
			r = $urandom_range(9, 0);
			if (r < 4) begin
				case ($urandom_range(3, 0))
					0: sz = 4'd0;
					1: sz = 4'd1;
					2: sz = 4'd8;
					default: sz = 4'd15;
				endcase
			end else begin
				sz = 4'($urandom_range(8, 1));
			end
			v = $urandom;
			v[3:0] = sz;
			set_reg(ppr_pkg::REG_PATTERN_SIZE, v);
			r = $urandom_range(19, 0);
			bw = shuffled_board();
			if (r < 14) v = bw[31:0];
			else if (r < 16) v = ppr_pkg::TILES_RESET;
			else if (r < 18) v = $urandom;
			else if (r == 18) v = '0;
			else v = '1;
			set_reg(ppr_pkg::REG_PATTERN_TILES, v);
			gaps_on = (ph % 4 != 1);
			// receiver holds off while words keep coming, so the block backs up
			if (ph == 3) begin
				gaps_on = 1'b0;
				hold_off = 1'b1;
			end
			for (n = 0; n < PHASE_WORDS; n++) put_board(random_board());
		end

		drain(40);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
